### src/cidt_pkg.sv
// Shared types and constants of the CAN identifier changed-bit tracker.
package cidt_pkg;

  localparam int ID_W    = 11;
  localparam int LEN_W   = 4;
  localparam int DATA_W  = 64;
  localparam int TOTAL_W = 16;
  localparam int ID_EXT_W  = 12;
  localparam int CNT_EXT_W = 32;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW
  } state_t;

endpackage

### src/cidt_if.sv
// Request and result channel interfaces of the changed-bit tracker.
interface cidt_in_if;
  logic                       valid;
  logic                       ready;
  logic [cidt_pkg::ID_W-1:0]  frame_id;
  logic [cidt_pkg::LEN_W-1:0] byte_count;
  logic [cidt_pkg::DATA_W-1:0] payload;

  modport source (output valid, frame_id, byte_count, payload, input ready);
  modport sink   (input valid, frame_id, byte_count, payload, output ready);
endinterface

interface cidt_out_if;
  logic                          valid;
  logic                          ready;
  logic [cidt_pkg::ID_W-1:0]     echo_id;
  logic [cidt_pkg::DATA_W-1:0]   changed_mask;
  logic [cidt_pkg::TOTAL_W-1:0]  frame_total;
  logic                          first_seen;

  modport source (output valid, echo_id, changed_mask, frame_total, first_seen,
                  input ready);
  modport sink   (input valid, echo_id, changed_mask, frame_total, first_seen,
                  output ready);
endinterface

### src/can_id_changed_bit_tracker.sv
// Top level: per-identifier changed-bit tracker over a read-modify-write table.
//
// Usage:
//   in_ch carries one CAN frame per request (frame_id, byte_count, payload).
//   out_ch returns one result per request: echo_id, changed_mask,
//   frame_total and first_seen for the entry just updated.
//   Timing: a request is accepted in ST_IDLE, where its table entry is read
//   into a register; in ST_RMW the entry is modified and written back and the
//   result loaded into the output register, both once that register is free.
//   No new request is taken until the previous one has been written back.
//   Reset: a clearing pass writes every one of the 2^ID_BITS entries,
//   one per cycle; in_ch.ready stays low meanwhile.
//   Stall: a result held by out_ch.ready low stays in the output register;
//   one more request is accepted and waits in the write-back step until the
//   output register frees, then in_ch.ready returns.
module can_id_changed_bit_tracker #(
  parameter int ID_BITS    = 11,
  parameter int COUNT_BITS = 16,
  parameter int MAX_BYTES  = 8
) (
  input logic clk,
  input logic rst_n,
  cidt_in_if.sink    in_ch,
  cidt_out_if.source out_ch
);

  localparam int DEPTH = 1 << ID_BITS;

  typedef struct packed {
    logic                        seen;
    logic [cidt_pkg::DATA_W-1:0] ref_data;
    logic [cidt_pkg::DATA_W-1:0] mask;
    logic [COUNT_BITS-1:0]       count;
  } entry_t;

  entry_t mem [DEPTH];

  cidt_pkg::state_t state_r, state_nxt;

  logic [ID_BITS-1:0]             clr_addr_r, clr_addr_nxt;
  logic [ID_BITS-1:0]             idx_r;
  logic [cidt_pkg::LEN_W-1:0]     len_r;
  logic [cidt_pkg::DATA_W-1:0]    pl_r;
  entry_t                         rd_data_r;

  logic                           out_valid_r, out_valid_nxt;
  logic [cidt_pkg::ID_W-1:0]      out_id_r;
  logic [cidt_pkg::DATA_W-1:0]    out_mask_r;
  logic [cidt_pkg::TOTAL_W-1:0]   out_total_r;
  logic                           out_first_r;

  logic                           in_acc;
  logic                           in_ready;
  logic                           load_out;
  logic                           mem_we;
  logic [ID_BITS-1:0]             mem_waddr;
  entry_t                         mem_wdata;
  entry_t                         upd;
  logic [ID_BITS-1:0]             in_idx;
  logic [cidt_pkg::ID_EXT_W-1:0]  in_id_ext;
  logic [cidt_pkg::ID_EXT_W-1:0]  echo_ext;
  logic [cidt_pkg::CNT_EXT_W-1:0] cnt_ext;
  logic [cidt_pkg::LEN_W-1:0]     len_c;
  logic [cidt_pkg::DATA_W-1:0]    win;
  logic                           first;

  assign in_id_ext = cidt_pkg::ID_EXT_W'(in_ch.frame_id);
  assign in_idx    = in_id_ext[ID_BITS-1:0];
  assign in_acc    = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cidt_pkg::ST_CLEAR: begin
        if (clr_addr_r == '1) state_nxt = cidt_pkg::ST_IDLE;
      end
      cidt_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = cidt_pkg::ST_RMW;
      end
      cidt_pkg::ST_RMW: begin
        if (load_out) state_nxt = cidt_pkg::ST_IDLE;
      end
      default: state_nxt = cidt_pkg::ST_CLEAR;
    endcase
  end

  // entry update
  always_comb begin
    len_c = (len_r > cidt_pkg::LEN_W'(MAX_BYTES)) ? cidt_pkg::LEN_W'(MAX_BYTES) : len_r;
    for (int k = 0; k < 8; k++) begin
      win[8*k +: 8] = {8{len_c > cidt_pkg::LEN_W'(k)}};
    end
    first        = !rd_data_r.seen;
    upd.seen     = 1'b1;
    upd.ref_data = first ? pl_r : rd_data_r.ref_data;
    upd.mask     = first ? '0
                         : (rd_data_r.mask | ((rd_data_r.ref_data ^ pl_r) & win));
    if (first) begin
      upd.count = COUNT_BITS'(1);
    end else if (rd_data_r.count == '1) begin
      upd.count = rd_data_r.count;
    end else begin
      upd.count = rd_data_r.count + COUNT_BITS'(1);
    end
    cnt_ext  = cidt_pkg::CNT_EXT_W'(upd.count);
    echo_ext = cidt_pkg::ID_EXT_W'(idx_r);
  end

  // state outputs
  always_comb begin
    in_ready     = 1'b0;
    load_out     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = idx_r;
    mem_wdata    = upd;
    clr_addr_nxt = clr_addr_r;
    case (state_r)
      cidt_pkg::ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + ID_BITS'(1);
      end
      cidt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      cidt_pkg::ST_RMW: begin
        load_out = !out_valid_r || out_ch.ready;
        mem_we   = load_out;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (in_acc) rd_data_r <= mem[in_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cidt_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r <= in_idx;
      len_r <= in_ch.byte_count;
      pl_r  <= in_ch.payload;
    end
    if (load_out) begin
      out_id_r    <= echo_ext[cidt_pkg::ID_W-1:0];
      out_mask_r  <= upd.mask;
      out_total_r <= cnt_ext[cidt_pkg::TOTAL_W-1:0];
      out_first_r <= first;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.echo_id      = out_id_r;
  assign out_ch.changed_mask = out_mask_r;
  assign out_ch.frame_total  = out_total_r;
  assign out_ch.first_seen   = out_first_r;

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cidt_pkg::ST_CLEAR |-> !in_ready)
    else $error("request taken during clearing pass");

  a_acc_to_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == cidt_pkg::ST_RMW)
    else $error("accepted request not followed by write-back");

  a_no_write_on_acc: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && in_acc))
    else $error("table write overlaps table read");

  a_result_from_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == cidt_pkg::ST_RMW))
    else $error("result without write-back");

endmodule

### sim/testbench.sv
// Self-checking testbench for the CAN identifier changed-bit tracker.
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG   = 20000;
  localparam int RAND_ITEMS = 550;
  localparam int HOT_IDS    = 12;
  localparam int ROWS       = 16;
  localparam logic [cidt_pkg::DATA_W-1:0] ONES = '1;

  typedef struct packed {
    logic [cidt_pkg::ID_W-1:0]    id;
    logic [cidt_pkg::DATA_W-1:0]  mask;
    logic [cidt_pkg::TOTAL_W-1:0] total;
    logic                         first;
  } track_result_t;

  typedef struct {
    logic [cidt_pkg::ID_W-1:0]   id;
    logic [cidt_pkg::LEN_W-1:0]  len;
    logic [cidt_pkg::DATA_W-1:0] data;
    bit                          typed;
    track_result_t               want;
  } frame_row_t;

  logic clk;
  logic rst_n;
  bit   idle_on;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  cidt_in_if  in_ch ();
  cidt_out_if out_ch ();

  can_id_changed_bit_tracker u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow of the identifier table
  bit                           id_seen      [2**cidt_pkg::ID_W];
  logic [cidt_pkg::DATA_W-1:0]  id_reference [2**cidt_pkg::ID_W];
  logic [cidt_pkg::DATA_W-1:0]  id_changed   [2**cidt_pkg::ID_W];
  logic [cidt_pkg::TOTAL_W-1:0] id_total     [2**cidt_pkg::ID_W];

  track_result_t pending_results[$];

  logic [cidt_pkg::ID_W-1:0]   hot_ids  [HOT_IDS];
  logic [cidt_pkg::DATA_W-1:0] hot_base [HOT_IDS];

  frame_row_t directed_rows [ROWS] = '{
    '{11'd0,    4'd8,  64'h0,                 1'b1, '{11'd0,    64'h0, 16'd1, 1'b1}},
    '{11'd2047, 4'd15, ONES,                  1'b1, '{11'd2047, 64'h0, 16'd1, 1'b1}},
    '{11'd0,    4'd8,  ONES,                  1'b1, '{11'd0,    ONES,  16'd2, 1'b0}},
    '{11'd2047, 4'd0,  64'h0,                 1'b1, '{11'd2047, 64'h0, 16'd2, 1'b0}},
    '{11'd5,    4'd3,  64'h1122334455667788,  1'b1, '{11'd5,    64'h0, 16'd1, 1'b1}},
    '{11'd5,    4'd8,  64'h1122334455667788,  1'b0, '0},
    '{11'd5,    4'd2,  64'hEEDDCCBBAA998877,  1'b0, '0},
    '{11'd5,    4'd12, 64'h0022334455667788,  1'b0, '0},
    '{11'd5,    4'd0,  64'h0,                 1'b0, '0},
    '{11'd1024, 4'd1,  64'hA5A5A5A5A5A5A5A5,  1'b1, '{11'd1024, 64'h0, 16'd1, 1'b1}},
    '{11'd1024, 4'd7,  64'h5A5A5A5A5A5A5A5A,  1'b0, '0},
    '{11'd1024, 4'd8,  64'hA5A5A5A5A5A5A5A5,  1'b0, '0},
    '{11'd1,    4'd4,  64'h0123456789ABCDEF,  1'b1, '{11'd1,    64'h0, 16'd1, 1'b1}},
    '{11'd2046, 4'd9,  64'hFEDCBA9876543210,  1'b1, '{11'd2046, 64'h0, 16'd1, 1'b1}},
    '{11'd1,    4'd15, 64'h8123456789ABCDEE,  1'b0, '0},
    '{11'd0,    4'd1,  64'h0,                 1'b0, '0}
  };

  function automatic track_result_t track_frame(logic [cidt_pkg::ID_W-1:0] id,
                                                logic [cidt_pkg::LEN_W-1:0] len,
                                                logic [cidt_pkg::DATA_W-1:0] data);
    track_result_t r;
    logic [cidt_pkg::DATA_W-1:0] window;
    if (len >= 4'd8) window = ONES;
    else window = (64'd1 << (8 * len)) - 64'd1;
    r.first = !id_seen[id];
    if (!id_seen[id]) begin
      id_seen[id]      = 1'b1;
      id_reference[id] = data;
      id_changed[id]   = '0;
      id_total[id]     = cidt_pkg::TOTAL_W'(1);
    end else begin
      id_changed[id] = id_changed[id] | ((id_reference[id] ^ data) & window);
      if (id_total[id] != '1) id_total[id] = id_total[id] + 1'b1;
    end
    r.id    = id;
    r.mask  = id_changed[id];
    r.total = id_total[id];
    return r;
  endfunction

  task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    mismatches++;
    $display("%0t: %s expected %h, got %h", $time, field, want, got);
  endtask

  // drive one request and wait for it to be taken; called at a rising edge
  task automatic send_frame(logic [cidt_pkg::ID_W-1:0] id,
                            logic [cidt_pkg::LEN_W-1:0] len,
                            logic [cidt_pkg::DATA_W-1:0] data, bit typed,
                            track_result_t want);
    track_result_t r;
    while (idle_on && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.frame_id   <= id;
    in_ch.byte_count <= len;
    in_ch.payload    <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = track_frame(id, len, data);
    pending_results = {pending_results, typed ? want : r};
  endtask

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) out_ch.ready <= !idle_on || ($urandom_range(99) >= 17);

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG) @(posedge clk);
    $display("can_id_changed_bit_tracker: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    track_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: expected no result, got id %h mask %h total %h", $time,
                 out_ch.echo_id, out_ch.changed_mask, out_ch.frame_total);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.echo_id !== want.id)
          note_mismatch("echo_id", 64'(want.id), 64'(out_ch.echo_id));
        if (out_ch.changed_mask !== want.mask)
          note_mismatch("changed_mask", want.mask, out_ch.changed_mask);
        if (out_ch.frame_total !== want.total)
          note_mismatch("frame_total", 64'(want.total), 64'(out_ch.frame_total));
        if (out_ch.first_seen !== want.first)
          note_mismatch("first_seen", 64'(want.first), 64'(out_ch.first_seen));
      end
    end
  end

  initial begin
    logic [cidt_pkg::ID_W-1:0]   id;
    logic [cidt_pkg::DATA_W-1:0] data;
    int                          k;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.frame_id   <= '0;
    in_ch.byte_count <= '0;
    in_ch.payload    <= '0;
    idle_on      = 1'b1;
    hot_ids[0]   = '0;
    hot_ids[1]   = '1;
    hot_base[0]  = {$urandom, $urandom};
    hot_base[1]  = {$urandom, $urandom};
    for (int i = 2; i < HOT_IDS; i++) begin
      hot_ids[i]  = cidt_pkg::ID_W'($urandom_range(2**cidt_pkg::ID_W - 1));
      hot_base[i] = {$urandom, $urandom};
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_frame(directed_rows[i].id, directed_rows[i].len, directed_rows[i].data,
                 directed_rows[i].typed, directed_rows[i].want);

    // hold off until the table has answered everything
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      idle_on = (n < 200) || (n >= 380);
      if ($urandom_range(9) < 3) begin
        id   = cidt_pkg::ID_W'($urandom_range(2**cidt_pkg::ID_W - 1));
        data = {$urandom, $urandom};
      end else begin
        k  = int'($urandom_range(HOT_IDS - 1));
        id = hot_ids[k];
        case ($urandom_range(3))
          0:       data = hot_base[k];
          3:       data = {$urandom, $urandom};
          default: data = hot_base[k] ^ ({$urandom, $urandom} & {$urandom, $urandom}
                                          & {$urandom, $urandom});
        endcase
      end
      send_frame(id, cidt_pkg::LEN_W'($urandom_range(15)), data, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;
    idle_on = 1'b1;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("can_id_changed_bit_tracker: match");
    else
      $display("can_id_changed_bit_tracker: mismatch");
    $finish;
  end

endmodule
